/* design/ihrf_pkg.sv */
// Shared types and constants for the IPv4 header receive filter.
package ihrf_pkg;

  localparam int unsigned PROTO_OFFSET  = 9;
  localparam int unsigned SRC_OFFSET    = 12;
  localparam int unsigned DST_OFFSET    = 16;
  localparam int unsigned ADDR_BYTES    = 4;
  localparam logic [7:0]  ICMP_PROTOCOL = 8'd1;
  localparam logic [15:0] SUM_GOOD      = 16'hFFFF;

  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_ADDRESS = 8'd0,
    CFG_SUBNET_MASK   = 8'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_BAD_SUM   = 2'd0,
    VERDICT_NOT_OURS  = 2'd1,
    VERDICT_ICMP      = 2'd2,
    VERDICT_OTHER     = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start_of_header;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  protocol;
    logic [31:0] source_address;
  } out_item_t;

  typedef struct packed {
    logic [31:0] local_address;
    logic [31:0] subnet_mask;
  } cfg_t;

endpackage

/* design/ihrf_accum.sv */
// Header byte accumulator: count, checksum, held fields and verdict.
module ihrf_accum #(
  parameter int unsigned HEADER_BYTES = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ihrf_pkg::in_item_t  item,
  input  ihrf_pkg::cfg_t      cfg,
  output logic              res_vld,
  output ihrf_pkg::out_item_t res
);
  import ihrf_pkg::*;

  localparam int unsigned CNT_W = $clog2(HEADER_BYTES + 1);
  localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(HEADER_BYTES - 1);
  localparam logic [CNT_W-1:0] END_COUNT = CNT_W'(HEADER_BYTES);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       high_r, high_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;

  logic [CNT_W-1:0] pos;
  logic [15:0]      sum_base;
  logic [15:0]      word;
  logic             do_add;
  logic [16:0]      raw_sum;
  logic [15:0]      folded;
  logic             active;
  logic             last;
  logic [31:0]      bcast;
  logic [7:0]       b;

  always_comb begin
    b        = item.header_byte;
    pos      = item.start_of_header ? '0 : count_r;
    sum_base = item.start_of_header ? '0 : sum_r;
    active   = pos < END_COUNT;
    last     = pos == LAST_POS;

    do_add = 1'b0;
    word   = '0;
    if (pos[0]) begin
      do_add = 1'b1;
      word   = {high_r, b};
    end else if (last) begin
      do_add = 1'b1;
      word   = {b, 8'h00};
    end
    raw_sum = {1'b0, sum_base} + {1'b0, word};
    folded  = raw_sum[15:0] + {15'd0, raw_sum[16]};

    count_nxt = count_r;
    sum_nxt   = sum_r;
    high_nxt  = high_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    if (en && active) begin
      count_nxt = pos + CNT_W'(1);
      sum_nxt   = do_add ? folded : sum_base;
      high_nxt  = pos[0] ? (item.start_of_header ? '0 : high_r) : b;
      if (pos == CNT_W'(PROTO_OFFSET)) begin
        proto_nxt = b;
      end
      if (pos >= CNT_W'(SRC_OFFSET) && pos < CNT_W'(SRC_OFFSET + ADDR_BYTES)) begin
        src_nxt = {src_r[23:0], b};
      end
      if (pos >= CNT_W'(DST_OFFSET) && pos < CNT_W'(DST_OFFSET + ADDR_BYTES)) begin
        dst_nxt = {dst_r[23:0], b};
      end
    end

    bcast   = (cfg.local_address & cfg.subnet_mask) | ~cfg.subnet_mask;
    res_vld = en && active && last;
    res.protocol       = proto_nxt;
    res.source_address = src_nxt;
    if (sum_nxt != SUM_GOOD) begin
      res.verdict = VERDICT_BAD_SUM;
    end else if (dst_nxt != cfg.local_address && dst_nxt != bcast) begin
      res.verdict = VERDICT_NOT_OURS;
    end else if (proto_nxt == ICMP_PROTOCOL) begin
      res.verdict = VERDICT_ICMP;
    end else begin
      res.verdict = VERDICT_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      high_r  <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      high_r  <= high_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= END_COUNT)
    else $error("byte count beyond header length");

  a_res_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> count_r == END_COUNT)
    else $error("result without a completed header");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.start_of_header) |=> count_r == CNT_W'(1))
    else $error("start byte did not restart the count");

endmodule

/* design/ihrf_outbuf.sv */
// Two-entry result buffer: output register plus skid stage.
module ihrf_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ihrf_pkg::out_item_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output ihrf_pkg::out_item_t out_data
);
  import ihrf_pkg::*;

  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_vld_r, out_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  logic      pop;

  always_comb begin
    pop          = out_vld_r && out_ready;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (pop || !out_vld_r) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_nxt     = push_data;
        skid_vld_nxt = push;
      end else begin
        out_nxt     = push_data;
        out_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign can_push  = !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with empty output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_vld_r)
    else $error("result pushed into full buffer");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_vld_r && !out_ready) |=> skid_vld_r && skid_r == $past(push_data))
    else $error("stalled result not held in skid stage");

endmodule

/* design/ipv4_header_rx_filter.sv */
// Top level of the IPv4 header receive filter.
// Takes one header byte per clock; in_ready is high unless two finished results are waiting.
// Each byte updates the count, checksum and held fields in the cycle it is accepted, and the
// verdict for the last byte (offset HEADER_BYTES-1) is registered at that same edge, so with
// the output register free out_valid rises in the cycle after the last byte. A start_of_header
// byte drops any partial header and gives no result of its own. Results sit in a
// two-entry output buffer; configuration writes are taken every cycle (cfg_ready is tied high).
module ipv4_header_rx_filter #(
  parameter int unsigned HEADER_BYTES = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ihrf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ihrf_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ihrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);
  import ihrf_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      en;
  logic      res_vld;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign en        = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOCAL_ADDRESS: cfg_nxt.local_address = cfg_data;
        CFG_SUBNET_MASK:   cfg_nxt.subnet_mask   = cfg_data;
        default:           cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ihrf_accum #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .item    (in_data),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  ihrf_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
